[hdl/mck_pkg.sv]
// ----------------------------------------------------------------------------
// mck_pkg: shared types and constants of the Morse character keyer
// Holds the sequencer state type, the decoded character record and the
// fixed element code table for digits and letters.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int TickWidth  = 16;
   localparam int CharWidth  = 8;
   localparam int MaxElems   = 5;
   localparam int LenWidth   = 3;
   localparam int CodeCount  = 36;
   localparam int IdxWidth   = 6;

   // Register indexes of the configuration port.
   localparam logic [1:0] RegDotTicks    = 2'd0;
   localparam logic [1:0] RegDashTicks   = 2'd1;
   localparam logic [1:0] RegElemGap     = 2'd2;
   localparam logic [1:0] RegLetterGap   = 2'd3;

   localparam logic [TickWidth-1:0] DotTicksReset   = 16'd500;
   localparam logic [TickWidth-1:0] DashTicksReset  = 16'd1500;
   localparam logic [TickWidth-1:0] ElemGapReset    = 16'd1500;
   localparam logic [TickWidth-1:0] LetterGapReset  = 16'd1000;

   // Character code boundaries.
   localparam logic [CharWidth-1:0] CharDigit0  = 8'd48;
   localparam logic [CharWidth-1:0] CharDigit9  = 8'd57;
   localparam logic [CharWidth-1:0] CharUpperA  = 8'd65;
   localparam logic [CharWidth-1:0] CharUpperZ  = 8'd90;
   localparam logic [CharWidth-1:0] CharLowerA  = 8'd97;
   localparam logic [CharWidth-1:0] CharLowerZ  = 8'd122;
   localparam logic [CharWidth-1:0] CharSpace   = 8'd32;
   localparam logic [CharWidth-1:0] UpperOffset = 8'd55;
   localparam logic [CharWidth-1:0] LowerOffset = 8'd87;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELEM_ON,
      ST_ELEM_GAP,
      ST_SPACE_OFF,
      ST_SPACE_GAP,
      ST_LETTER_GAP
   } state_type;

   // Pattern bit 0 is the first element; a set bit is a dash.
   typedef struct packed {
      logic                  coded;
      logic                  space;
      logic [LenWidth-1:0]   len;
      logic [MaxElems-1:0]   pattern;
   } char_info_type;

   // Each entry is {length, pattern}; entries 0-9 digits, 10-35 letters A-Z.
   localparam logic [LenWidth+MaxElems-1:0] CODE_TABLE [CodeCount] = '{
      8'b101_11111, 8'b101_11110, 8'b101_11100, 8'b101_11000, 8'b101_10000,
      8'b101_00000, 8'b101_00001, 8'b101_00011, 8'b101_00111, 8'b101_01111,
      8'b010_00010, 8'b100_00001, 8'b100_00101, 8'b011_00001, 8'b001_00000,
      8'b100_00100, 8'b011_00011, 8'b100_00000, 8'b010_00000, 8'b100_01110,
      8'b011_00101, 8'b100_00010, 8'b010_00011, 8'b010_00001, 8'b011_00111,
      8'b100_00110, 8'b100_01011, 8'b011_00010, 8'b011_00000, 8'b001_00001,
      8'b011_00100, 8'b100_01000, 8'b011_00110, 8'b100_01001, 8'b100_01101,
      8'b100_00011
   };

endpackage

[hdl/morse_character_keyer.sv]
// ----------------------------------------------------------------------------
// morse_character_keyer: Morse code keyer for one character per beat
// Turns an ASCII character into the timed key-on/key-off segments that send
// it, under a small element sequencer.
// ----------------------------------------------------------------------------
// Usage.
// The request channel (req_) takes one character per beat in req_tdata[7:0].
// The response channel (rsp_) gives one keying segment per beat: key level in
// rsp_tdata[0] and duration in ticks in rsp_tdata[16:1]. Each dot or dash
// gives a key-on segment and a key-off element gap; a space gives a key-off
// segment of dash length and an element gap; uncoded characters give no
// elements. Every character closes with a letter gap beat carrying rsp_tlast.
// An n-element character gives 2n+1 segments (one to eleven), one per cycle
// while the receiver takes them; the sequencer serves one character at a
// time, taking a new one only in idle. The request beat moves it out of idle;
// the output register then loads the first segment. A receiver stall holds
// the output beat and the sequencer with it; no segment is lost. The timing
// registers are written through csr_; the user must do so only while the
// keyer is idle, as the block does not enforce it. Synchronous reset returns
// the sequencer to idle, empties the output register and loads the default
// timings: dot 500, dash 1500, element gap 1500, letter gap 1000 ticks.
// ----------------------------------------------------------------------------
module morse_character_keyer (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mck_pkg::CharWidth-1:0]   req_tdata,   // [7:0] char_code
   // Response channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // [0] key_level, [16:1] seg_ticks, zero pad
   output logic                            rsp_tlast,
   // Timing register write port.
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [mck_pkg::TickWidth-1:0]   csr_wdata
);

   // Timing registers.
   logic [mck_pkg::TickWidth-1:0] dot_ticks_ff;
   logic [mck_pkg::TickWidth-1:0] dash_ticks_ff;
   logic [mck_pkg::TickWidth-1:0] elem_gap_ff;
   logic [mck_pkg::TickWidth-1:0] letter_gap_ff;

   // Sequencer.
   mck_pkg::state_type            state_ff, state_in;
   logic [mck_pkg::MaxElems-1:0]  pattern_ff, pattern_in;
   logic [mck_pkg::LenWidth-1:0]  remain_ff, remain_in;

   // Output register.
   logic                          out_valid_ff, out_valid_in;
   logic                          out_level_ff, out_level_in;
   logic [mck_pkg::TickWidth-1:0] out_ticks_ff, out_ticks_in;
   logic                          out_last_ff, out_last_in;

   mck_pkg::char_info_type        info;
   logic                          req_fire;
   logic                          out_free;
   logic                          emit;
   logic                          seg_level;
   logic [mck_pkg::TickWidth-1:0] seg_ticks;
   logic                          seg_last;

   mck_char_decode u_decode (
      .char_code (req_tdata),
      .info      (info)
   );

   assign req_tready = (state_ff == mck_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // The output register can take a segment when it is empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit       = (state_ff != mck_pkg::ST_IDLE) && out_free;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ticks_ff  <= mck_pkg::DotTicksReset;
         dash_ticks_ff <= mck_pkg::DashTicksReset;
         elem_gap_ff   <= mck_pkg::ElemGapReset;
         letter_gap_ff <= mck_pkg::LetterGapReset;
      end else if (csr_we) begin
         unique case (csr_index)
            mck_pkg::RegDotTicks:  dot_ticks_ff  <= csr_wdata;
            mck_pkg::RegDashTicks: dash_ticks_ff <= csr_wdata;
            mck_pkg::RegElemGap:   elem_gap_ff   <= csr_wdata;
            mck_pkg::RegLetterGap: letter_gap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mck_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (info.coded) begin
                  state_in = mck_pkg::ST_ELEM_ON;
               end else if (info.space) begin
                  state_in = mck_pkg::ST_SPACE_OFF;
               end else begin
                  state_in = mck_pkg::ST_LETTER_GAP;
               end
            end
         end
         mck_pkg::ST_ELEM_ON: begin
            if (emit) state_in = mck_pkg::ST_ELEM_GAP;
         end
         mck_pkg::ST_ELEM_GAP: begin
            if (emit) begin
               state_in = (remain_ff == mck_pkg::LenWidth'(1)) ? mck_pkg::ST_LETTER_GAP
                                                               : mck_pkg::ST_ELEM_ON;
            end
         end
         mck_pkg::ST_SPACE_OFF: begin
            if (emit) state_in = mck_pkg::ST_SPACE_GAP;
         end
         mck_pkg::ST_SPACE_GAP: begin
            if (emit) state_in = mck_pkg::ST_LETTER_GAP;
         end
         mck_pkg::ST_LETTER_GAP: begin
            if (emit) state_in = mck_pkg::ST_IDLE;
         end
         default: state_in = mck_pkg::ST_IDLE;
      endcase
   end

   // Segment selected by the current state.
   always_comb begin
      seg_level = 1'b0;
      seg_ticks = letter_gap_ff;
      seg_last  = 1'b0;
      unique case (state_ff)
         mck_pkg::ST_ELEM_ON: begin
            seg_level = 1'b1;
            seg_ticks = pattern_ff[0] ? dash_ticks_ff : dot_ticks_ff;
         end
         mck_pkg::ST_ELEM_GAP,
         mck_pkg::ST_SPACE_GAP:  seg_ticks = elem_gap_ff;
         mck_pkg::ST_SPACE_OFF:  seg_ticks = dash_ticks_ff;
         mck_pkg::ST_LETTER_GAP: seg_last  = 1'b1;
         default: ;
      endcase
   end

   // Element pattern shifter and count of elements still to send.
   always_comb begin
      pattern_in = pattern_ff;
      remain_in  = remain_ff;
      if (req_fire) begin
         pattern_in = info.pattern;
         remain_in  = info.len;
      end else if (emit && (state_ff == mck_pkg::ST_ELEM_GAP)) begin
         pattern_in = pattern_ff >> 1;
         remain_in  = remain_ff - mck_pkg::LenWidth'(1);
      end
   end

   // Output register loading.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_level_in = out_level_ff;
      out_ticks_in = out_ticks_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_level_in = seg_level;
         out_ticks_in = seg_ticks;
         out_last_in  = seg_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mck_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff   <= pattern_in;
      remain_ff    <= remain_in;
      out_level_ff <= out_level_in;
      out_ticks_ff <= out_ticks_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ticks_ff, out_level_ff};
   assign rsp_tlast  = out_last_ff;

   // A closing letter gap is always a key-off segment.
   a_last_is_off : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[0])
      else $error("letter gap beat carries key-on level");

   // The sequencer only returns to idle by loading the closing letter gap.
   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      $rose(req_tready) |-> rsp_tvalid && rsp_tlast)
      else $error("sequencer went idle without emitting the letter gap");

   // A key-on segment is always followed by its element gap.
   a_on_then_gap : assert property (@(posedge clock) disable iff (reset)
      emit && seg_level |=> state_ff == mck_pkg::ST_ELEM_GAP)
      else $error("key-on segment not followed by an element gap");

   // The element count never runs out while elements are being sent.
   a_remain_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == mck_pkg::ST_ELEM_ON || state_ff == mck_pkg::ST_ELEM_GAP)
      |-> remain_ff != '0)
      else $error("element sequencer running with no elements left");

endmodule

[hdl/mck_char_decode.sv]
// ----------------------------------------------------------------------------
// mck_char_decode: character classifier and code table lookup
// Sorts a character into digit, letter, space or uncoded, and returns the
// element count and dot/dash pattern of coded characters.
// ----------------------------------------------------------------------------
module mck_char_decode (
   input  logic [mck_pkg::CharWidth-1:0] char_code,
   output mck_pkg::char_info_type        info
);

   logic                               is_digit;
   logic                               is_upper;
   logic                               is_lower;
   logic [mck_pkg::CharWidth-1:0]      offset;
   logic [mck_pkg::CharWidth-1:0]      diff;
   logic [mck_pkg::IdxWidth-1:0]       idx;
   logic [mck_pkg::LenWidth+mck_pkg::MaxElems-1:0] entry;

   assign is_digit = (char_code >= mck_pkg::CharDigit0) && (char_code <= mck_pkg::CharDigit9);
   assign is_upper = (char_code >= mck_pkg::CharUpperA) && (char_code <= mck_pkg::CharUpperZ);
   assign is_lower = (char_code >= mck_pkg::CharLowerA) && (char_code <= mck_pkg::CharLowerZ);

   always_comb begin
      priority if (is_digit) begin
         offset = mck_pkg::CharDigit0;
      end else if (is_lower) begin
         offset = mck_pkg::LowerOffset;
      end else begin
         offset = mck_pkg::UpperOffset;
      end
   end

   assign diff  = char_code - offset;
   assign idx   = diff[mck_pkg::IdxWidth-1:0];
   // Out-of-range indexes only occur for uncoded characters, whose entry is unused.
   assign entry = (idx < mck_pkg::IdxWidth'(mck_pkg::CodeCount))
                  ? mck_pkg::CODE_TABLE[idx] : '0;

   always_comb begin
      info.coded   = is_digit || is_upper || is_lower;
      info.space   = (char_code == mck_pkg::CharSpace);
      info.len     = entry[mck_pkg::LenWidth+mck_pkg::MaxElems-1:mck_pkg::MaxElems];
      info.pattern = entry[mck_pkg::MaxElems-1:0];
   end

endmodule
